// ===== hw/rtl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, constants and a lookup function for the calendar month stepper.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned DAYS_W  = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned SUM_W   = 14;
    localparam int unsigned Q100_W  = 7;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;

    // reciprocal constants: x*RECIP_100 >> SHIFT_100 == x/100, x*RECIP_7 >> SHIFT_7 == x/7
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned SHIFT_100 = 19;
    localparam logic [15:0] RECIP_7   = 16'd37450;
    localparam int unsigned SHIFT_7   = 18;

    typedef enum logic [REQ_W-1:0] {
        REQ_NEXT_MONTH = 3'd0,
        REQ_PREV_MONTH = 3'd1,
        REQ_NEXT_YEAR  = 3'd2,
        REQ_PREV_YEAR  = 3'd3,
        REQ_LOAD       = 3'd4
    } t_req;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_cal_state;

    // (31 * m) / 12 for March-based month m = 1..12
    function automatic logic [DAYS_W-1:0] f_month_shift(input logic [MONTH_W-1:0] m);
        logic [DAYS_W-1:0] v;
        begin
            case (m)
                4'd1:    v = 5'd2;
                4'd2:    v = 5'd5;
                4'd3:    v = 5'd7;
                4'd4:    v = 5'd10;
                4'd5:    v = 5'd12;
                4'd6:    v = 5'd15;
                4'd7:    v = 5'd18;
                4'd8:    v = 5'd20;
                4'd9:    v = 5'd23;
                4'd10:   v = 5'd25;
                4'd11:   v = 5'd28;
                4'd12:   v = 5'd31;
                default: v = 5'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== hw/rtl/cms_step.sv =====
// ----------------------------------------------------------------------------
// cms_step
// Next month/year from the current state and one request.
// ----------------------------------------------------------------------------
module cms_step (
    input  cms_pkg::t_cal_state            i_cur,
    input  logic [cms_pkg::REQ_W-1:0]      i_req,
    input  logic [cms_pkg::MONTH_W-1:0]    i_load_month,
    input  logic [cms_pkg::YEAR_W-1:0]     i_load_year,
    output cms_pkg::t_cal_state            o_nxt
);
    import cms_pkg::*;

    logic [MONTH_W-1:0] lm_clamp;
    logic [YEAR_W-1:0]  ly_clamp;

    always_comb begin
        if (i_load_month == '0) begin
            lm_clamp = MONTH_JAN;
        end else if (i_load_month > MONTH_DEC) begin
            lm_clamp = MONTH_DEC;
        end else begin
            lm_clamp = i_load_month;
        end
        if (i_load_year == '0) begin
            ly_clamp = YEAR_MIN;
        end else if (i_load_year > YEAR_MAX) begin
            ly_clamp = YEAR_MAX;
        end else begin
            ly_clamp = i_load_year;
        end
    end

    always_comb begin
        o_nxt = i_cur;
        case (i_req)
            REQ_NEXT_MONTH: begin
                if (i_cur.month != MONTH_DEC) begin
                    o_nxt.month = i_cur.month + 4'd1;
                end else if (i_cur.year < YEAR_MAX) begin
                    o_nxt.month = MONTH_JAN;
                    o_nxt.year  = i_cur.year + 14'd1;
                end
            end
            REQ_PREV_MONTH: begin
                if (i_cur.month != MONTH_JAN) begin
                    o_nxt.month = i_cur.month - 4'd1;
                end else if (i_cur.year > YEAR_MIN) begin
                    o_nxt.month = MONTH_DEC;
                    o_nxt.year  = i_cur.year - 14'd1;
                end
            end
            REQ_NEXT_YEAR: begin
                if (i_cur.year < YEAR_MAX) begin
                    o_nxt.year = i_cur.year + 14'd1;
                end
            end
            REQ_PREV_YEAR: begin
                if (i_cur.year > YEAR_MIN) begin
                    o_nxt.year = i_cur.year - 14'd1;
                end
            end
            REQ_LOAD: begin
                o_nxt.month = lm_clamp;
                o_nxt.year  = ly_clamp;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cms_cal.sv =====
// ----------------------------------------------------------------------------
// cms_cal
// Calendar info pipeline: leap flag, month length and weekday of the 1st.
// Three register stages with per-stage valid/ready.
// ----------------------------------------------------------------------------
module cms_cal (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  cms_pkg::t_cal_state            i_state,
    output logic                           o_valid,
    input  logic                           i_ready,
    output cms_pkg::t_cal_state            o_state,
    output logic                           o_leap,
    output logic [cms_pkg::DAYS_W-1:0]     o_days,
    output logic [cms_pkg::WDAY_W-1:0]     o_wday
);
    import cms_pkg::*;

    // stage 1: captured state
    logic               r_s1_valid;
    t_cal_state         r_s1_state;
    // stage 2: day sum and year/100
    logic               r_s2_valid;
    t_cal_state         r_s2_state;
    logic [SUM_W-1:0]   r_s2_sum;
    logic [Q100_W-1:0]  r_s2_yq;
    // output register
    logic               r_o_valid;
    t_cal_state         r_o_state;
    logic               r_o_leap;
    logic [DAYS_W-1:0]  r_o_days;
    logic [WDAY_W-1:0]  r_o_wday;

    logic s1_load, s2_load, out_load;

    assign out_load = r_s2_valid && (!r_o_valid || i_ready);
    assign s2_load  = r_s1_valid && (!r_s2_valid || out_load);
    assign s1_load  = i_valid && (!r_s1_valid || s2_load);
    assign o_ready  = !r_s1_valid || s2_load;

    // stage 1 -> 2: shift-by-March sum
    logic               jf;
    logic [YEAR_W-1:0]  yy;
    logic [MONTH_W-1:0] mm;
    logic [26:0]        yy_prod;
    logic [26:0]        y_prod;
    logic [Q100_W-1:0]  yy_q100;
    logic [Q100_W-1:0]  y_q100;
    logic [SUM_W-1:0]   n_sum;

    always_comb begin
        jf      = (r_s1_state.month <= MONTH_FEB);
        yy      = r_s1_state.year - {13'd0, jf};
        mm      = jf ? (r_s1_state.month + 4'd10) : (r_s1_state.month - 4'd2);
        yy_prod = {13'd0, yy} * {14'd0, RECIP_100};
        y_prod  = {13'd0, r_s1_state.year} * {14'd0, RECIP_100};
        yy_q100 = yy_prod[SHIFT_100 +: Q100_W];
        y_q100  = y_prod[SHIFT_100 +: Q100_W];
        n_sum   = yy + {2'd0, yy[YEAR_W-1:2]} - {7'd0, yy_q100}
                + {9'd0, yy_q100[Q100_W-1:2]} + {9'd0, f_month_shift(mm)};
    end

    // stage 2 -> out: leap, days, sum mod 7
    logic [29:0]        s_prod;
    logic [11:0]        q7;
    logic [SUM_W-1:0]   q7x7;
    logic [SUM_W-1:0]   rem7;
    logic [YEAR_W-1:0]  yq_x100;
    logic               n_leap;
    logic [DAYS_W-1:0]  n_days;

    always_comb begin
        s_prod  = {16'd0, r_s2_sum} * {14'd0, RECIP_7};
        q7      = s_prod[SHIFT_7 +: 12];
        q7x7    = {q7[10:0], 3'd0} - {2'd0, q7};
        rem7    = r_s2_sum - q7x7;
        yq_x100 = {1'b0, r_s2_yq, 6'd0} + {2'd0, r_s2_yq, 5'd0} + {5'd0, r_s2_yq, 2'd0};
        n_leap  = (r_s2_state.year[1:0] == 2'd0)
                && ((yq_x100 != r_s2_state.year) || (r_s2_yq[1:0] == 2'd0));
        case (r_s2_state.month)
            4'd4, 4'd6, 4'd9, 4'd11: n_days = 5'd30;
            MONTH_FEB:               n_days = n_leap ? 5'd29 : 5'd28;
            default:                 n_days = 5'd31;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (out_load) begin
                r_s2_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_state <= i_state;
        end
        if (s2_load) begin
            r_s2_state <= r_s1_state;
            r_s2_sum   <= n_sum;
            r_s2_yq    <= y_q100;
        end
        if (out_load) begin
            r_o_state <= r_s2_state;
            r_o_leap  <= n_leap;
            r_o_days  <= n_days;
            r_o_wday  <= rem7[WDAY_W-1:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_state = r_o_state;
    assign o_leap  = r_o_leap;
    assign o_days  = r_o_days;
    assign o_wday  = r_o_wday;

endmodule

// ===== hw/rtl/calendar_month_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_month_stepper
// Gregorian month/year navigator reporting leap flag, month length and
// weekday of the 1st (0 = Monday).
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                         | tuser
//  s_axis   | in  | load_month[3:0] load_year[17:4]            | req_type[2:0]
//  m_axis   | out | month[3:0] year[17:4] leap[18] days[23:19] | -
//                   wday[26:24]
//
// One request per cycle sustained while the output is not stalled; each
// result passes state capture, day-sum multiply and mod-7 multiply.
// Current month/year update at accept, so requests chain back to back.
// Reset gives January 2000 and an empty pipeline.
// A stalled output holds; input keeps flowing until all three stages fill.
// ----------------------------------------------------------------------------
module calendar_month_stepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // load_month[3:0], load_year[17:4]
    input  logic [2:0]  i_s_axis_tuser,   // req_type[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // month, year, leap, days, wday
);
    import cms_pkg::*;

    t_cal_state         r_cur;
    t_cal_state         n_cur;
    t_cal_state         out_state;
    logic               accept;
    logic               out_leap;
    logic [DAYS_W-1:0]  out_days;
    logic [WDAY_W-1:0]  out_wday;

    cms_step u_step (
        .i_cur        (r_cur),
        .i_req        (i_s_axis_tuser),
        .i_load_month (i_s_axis_tdata[3:0]),
        .i_load_year  (i_s_axis_tdata[17:4]),
        .o_nxt        (n_cur)
    );

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.month <= MONTH_JAN;
            r_cur.year  <= YEAR_RST;
        end else if (accept) begin
            r_cur <= n_cur;
        end
    end

    cms_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_state (n_cur),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_state (out_state),
        .o_leap  (out_leap),
        .o_days  (out_days),
        .o_wday  (out_wday)
    );

    assign o_m_axis_tdata = {5'd0, out_wday, out_days, out_leap,
                             out_state.year, out_state.month};

endmodule

// ===== hw/rtl/cms_checker.sv =====
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks for the calendar month stepper.
// ----------------------------------------------------------------------------
module cms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[3:0] >= 4'd1 && o_m_axis_tdata[3:0] <= 4'd12
            && o_m_axis_tdata[17:4] >= 14'd1 && o_m_axis_tdata[17:4] <= 14'd9999
            && o_m_axis_tdata[26:24] <= 3'd6 && o_m_axis_tdata[31:27] == 5'd0)
        else $error("result field out of range");

    a_feb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3:0] == 4'd2
            |-> o_m_axis_tdata[23:19] == (5'd28 + {4'd0, o_m_axis_tdata[18]}))
        else $error("february length disagrees with leap flag");

    a_leap4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[18] |-> o_m_axis_tdata[5:4] == 2'd0)
        else $error("leap flag on year not divisible by four");

endmodule

bind calendar_month_stepper cms_checker u_cms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
